// ----- rtl/sha_pkg.sv -----
// ============================================================================
// sha_pkg
// Shared types, constants and functions for the SHA-256 byte stream hasher.
// ============================================================================
package sha_pkg;

    typedef logic [31:0] word_t;

    // request from the control path to the message buffer
    typedef struct packed {
        logic       put;
        logic [7:0] data;
        logic       len_wr;
        logic       len_lo;
        word_t      len_word;
    } buf_req_t;

    // round sequencer position, seen by the message buffer
    typedef struct packed {
        logic       run;
        logic [1:0] phase;
        logic [5:0] round;
    } sched_ctrl_t;

    localparam logic [1:0] PH_ADDR0 = 2'd0;
    localparam logic [1:0] PH_ADDR1 = 2'd1;
    localparam logic [1:0] PH_WORD  = 2'd2;
    localparam logic [1:0] PH_ROUND = 2'd3;

    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [5:0] BLOCK_LAST  = 6'd63;
    localparam logic [5:0] PAD_STOP    = 6'd56;
    localparam logic [3:0] LEN_HI_ADDR = 4'd14;
    localparam logic [3:0] LEN_LO_ADDR = 4'd15;
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [2:0] LAST_IDX    = 3'd7;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ----- rtl/sha256_byte_stream_hasher.sv -----
// ============================================================================
// sha256_byte_stream_hasher
// SHA-256 over a byte stream; emits the eight digest words at end of message.
// ============================================================================
// Bytes are taken one per cycle while a 64-byte block fills. The transaction
// that completes a block stalls the input until compression is done: the
// block lives in a 16-word memory with two read ports and one write port, and
// each of the 64 rounds steps through ADDR0, ADDR1 and WORD to read and expand
// one schedule word, then ROUND for the round itself. At end of message the
// block writes padding one byte per cycle (up to 64 bytes), pausing while an
// extra block is compressed, then two length words, runs the final compression
// and presents H0 to H7, one transaction each, after which it starts afresh.
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    localparam logic [2:0] ST_IN     = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_LEN_HI = 3'd2;
    localparam logic [2:0] ST_LEN_LO = 3'd3;
    localparam logic [2:0] ST_COMP   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [63:0] bit_len_reg;
    logic [2:0]  idx_reg;
    logic        pend_end_reg;
    logic        pad_first_reg;
    logic        final_reg;
    logic        s_acc;
    logic        block_full;
    logic        comp_start;
    logic        out_done;
    logic        comp_done;
    logic [5:0]  byte_pos;
    buf_req_t    req;
    sched_ctrl_t sched;
    word_t       w_word;
    word_t       dig_word;

    assign s_tready = (state_reg == ST_IN);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign out_done = m_tvalid && m_tready && (idx_reg == LAST_IDX);

    always_comb begin
        req          = '0;
        req.data     = s_tdata;
        req.len_word = bit_len_reg[63:32];
        unique case (state_reg)
            ST_IN: begin
                req.put = s_acc && s_tuser;
            end
            ST_PAD: begin
                req.put  = pad_first_reg || (byte_pos != PAD_STOP);
                req.data = pad_first_reg ? PAD_BYTE : 8'd0;
            end
            ST_LEN_HI: begin
                req.len_wr = 1'b1;
            end
            ST_LEN_LO: begin
                req.len_wr   = 1'b1;
                req.len_lo   = 1'b1;
                req.len_word = bit_len_reg[31:0];
            end
            default: begin
            end
        endcase
    end

    assign block_full = req.put && (byte_pos == BLOCK_LAST);
    assign comp_start = block_full || (state_reg == ST_LEN_LO);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IN: begin
                if (s_acc) begin
                    if (block_full) begin
                        state_next = ST_COMP;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (block_full) begin
                    state_next = ST_COMP;
                end else if (!req.put) begin
                    state_next = ST_LEN_HI;
                end
            end
            ST_LEN_HI: state_next = ST_LEN_LO;
            ST_LEN_LO: state_next = ST_COMP;
            ST_COMP: begin
                if (comp_done) begin
                    priority if (final_reg) begin
                        state_next = ST_OUT;
                    end else if (pend_end_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IN;
                    end
                end
            end
            ST_OUT: begin
                if (out_done) begin
                    state_next = ST_IN;
                end
            end
            default: state_next = ST_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IN;
            bit_len_reg   <= 64'd0;
            idx_reg       <= 3'd0;
            pend_end_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            final_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_acc && s_tuser) begin
                bit_len_reg <= bit_len_reg + 64'd8;
            end
            if (s_acc && s_tlast) begin
                pend_end_reg  <= 1'b1;
                pad_first_reg <= 1'b1;
            end
            if (state_reg == ST_PAD && req.put) begin
                pad_first_reg <= 1'b0;
            end
            if (state_reg == ST_LEN_LO) begin
                final_reg <= 1'b1;
            end
            if (m_tvalid && m_tready) begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (out_done) begin
                bit_len_reg  <= 64'd0;
                pend_end_reg <= 1'b0;
                final_reg    <= 1'b0;
            end
        end
    end

    sha_msg_buf u_msg_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .sched    (sched),
        .restart  (out_done),
        .byte_pos (byte_pos),
        .w_word   (w_word)
    );

    sha_round_core u_round_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (comp_start),
        .restart  (out_done),
        .w_word   (w_word),
        .dig_idx  (idx_reg),
        .sched    (sched),
        .done     (comp_done),
        .dig_word (dig_word)
    );

    assign m_tdata = dig_word;
    assign m_tuser = idx_reg;
    assign m_tlast = (idx_reg == LAST_IDX);

`ifndef SYNTHESIS
    a_one_side_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result channels open together");

    a_end_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after end of message");

    a_reopen_after_digest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not ready for a new message after digest");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        comp_start |-> !sched.run)
        else $error("compression started while rounds in progress");
`endif

endmodule

// ----- rtl/sha_msg_buf.sv -----
// ============================================================================
// sha_msg_buf
// Message block memory: packs bytes big-endian into 16 words and expands the
// message schedule in place during compression.
// ============================================================================
module sha_msg_buf
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  buf_req_t    req,
    input  sched_ctrl_t sched,
    input  logic        restart,
    output logic [5:0]  byte_pos,
    output word_t       w_word
);

    word_t       sched_mem [16];
    word_t       rd_a_reg;
    word_t       rd_b_reg;
    word_t       psum_reg;
    word_t       wlow_reg;
    word_t       w_reg;
    word_t       w_next;
    logic [23:0] acc_reg;
    logic [5:0]  pos_reg;
    logic [3:0]  rd_addr_a;
    logic [3:0]  rd_addr_b;
    logic        wr_en;
    logic [3:0]  wr_addr;
    word_t       wr_data;
    logic        expand;

    assign expand = (sched.round[5:4] != 2'd0);

    always_comb begin
        if (sched.phase == PH_ADDR0) begin
            rd_addr_a = sched.round[3:0];
            rd_addr_b = sched.round[3:0] + 4'd1;
        end else begin
            rd_addr_a = sched.round[3:0] + 4'd9;
            rd_addr_b = sched.round[3:0] + 4'd14;
        end
    end

    assign w_next = expand ? (psum_reg + rd_a_reg + small_sigma1(rd_b_reg)) : wlow_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sched.round[3:0];
        wr_data = w_next;
        priority if (sched.run && sched.phase == PH_WORD && expand) begin
            wr_en = 1'b1;
        end else if (req.put && pos_reg[1:0] == 2'd3) begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[5:2];
            wr_data = {acc_reg, req.data};
        end else if (req.len_wr) begin
            wr_en   = 1'b1;
            wr_addr = req.len_lo ? LEN_LO_ADDR : LEN_HI_ADDR;
            wr_data = req.len_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sched_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= sched_mem[rd_addr_a];
        rd_b_reg <= sched_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (sched.phase == PH_ADDR1) begin
            psum_reg <= rd_a_reg + small_sigma0(rd_b_reg);
            wlow_reg <= rd_a_reg;
        end
        if (sched.phase == PH_WORD) begin
            w_reg <= w_next;
        end
        if (req.put) begin
            acc_reg <= {acc_reg[15:0], req.data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 6'd0;
        end else if (restart) begin
            pos_reg <= 6'd0;
        end else if (req.put) begin
            pos_reg <= pos_reg + 6'd1;
        end
    end

    assign byte_pos = pos_reg;
    assign w_word   = w_reg;

endmodule

// ----- rtl/sha_round_core.sv -----
// ============================================================================
// sha_round_core
// Round sequencer, working variables and chaining words.
// ============================================================================
module sha_round_core
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        restart,
    input  word_t       w_word,
    input  logic [2:0]  dig_idx,
    output sched_ctrl_t sched,
    output logic        done,
    output word_t       dig_word
);

    word_t      h_reg [8];
    word_t      v_reg [8];
    word_t      hk_reg;
    word_t      t1;
    word_t      t2;
    logic       run_reg;
    logic       fin_reg;
    logic [1:0] phase_reg;
    logic [5:0] round_reg;

    assign t1 = hk_reg + w_word + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]));
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            phase_reg <= PH_ADDR0;
            round_reg <= 6'd0;
        end else begin
            fin_reg <= 1'b0;
            if (start) begin
                run_reg   <= 1'b1;
                phase_reg <= PH_ADDR0;
                round_reg <= 6'd0;
            end else if (run_reg) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_ROUND) begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == LAST_ROUND) begin
                        run_reg <= 1'b0;
                        fin_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (run_reg) begin
            if (phase_reg == PH_ADDR0) begin
                hk_reg <= v_reg[7] + ROUND_K[round_reg];
            end
            if (phase_reg == PH_ROUND) begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= INIT_H[i];
            end
        end else if (fin_reg) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign sched.run   = run_reg;
    assign sched.phase = phase_reg;
    assign sched.round = round_reg;
    assign done        = fin_reg;
    assign dig_word    = h_reg[dig_idx];

endmodule

// ----- test/sha256_digest_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// sha256_digest_checker
// Watches both streams of the hasher and rebuilds every message from the
// accepted input transactions. On each end of message it computes the SHA-256
// digest itself and queues the eight words. Each accepted output transaction
// is then compared field by field, in order, against the oldest queued word.
// ============================================================================
module sha256_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          words_pending,
    output int          words_checked
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LENGTH_SLOT  = 6'd56;
    localparam logic [5:0] BLOCK_END    = 6'd63;
    localparam logic [2:0] FINAL_INDEX  = 3'd7;

    logic [31:0]  hash_h [8];
    logic [31:0]  msg_blk [16];
    logic [5:0]   fill;
    logic [63:0]  nbits;
    digest_word_t digest_q [$];
    int           errs;
    int           checked;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_message();
        for (int i = 0; i < 8; i++) hash_h[i] = H_START[i];
        fill  = '0;
        nbits = '0;
    endtask

    task automatic mix_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = msg_blk[t];
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_h[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
    endtask

    // place a byte big-endian in the block; compress once it is full
    task automatic pack_byte(input logic [7:0] b);
        int shift;
        shift = (3 - fill[1:0]) * 8;
        if (fill[1:0] == 2'd0) begin
            msg_blk[fill[5:2]] = {24'd0, b} << shift;
        end else begin
            msg_blk[fill[5:2]] = msg_blk[fill[5:2]] | ({24'd0, b} << shift);
        end
        if (fill == BLOCK_END) begin
            mix_block();
            fill = '0;
        end else begin
            fill = fill + 6'd1;
        end
    endtask

    task automatic take_item(input logic [7:0] d, input logic p, input logic e);
        logic [63:0]  len;
        digest_word_t ent;
        if (p) begin
            nbits = nbits + 64'd8;
            pack_byte(d);
        end
        if (e) begin
            len = nbits;
            pack_byte(PAD_MARK);
            while (fill != LENGTH_SLOT) pack_byte(8'd0);
            msg_blk[14] = len[63:32];
            msg_blk[15] = len[31:0];
            mix_block();
            for (int k = 0; k < 8; k++) begin
                ent.word = hash_h[k];
                ent.idx  = 3'(k);
                ent.last = (3'(k) == FINAL_INDEX);
                digest_q.push_back(ent);
            end
            restart_message();
        end
    endtask

    initial begin
        errs    = 0;
        checked = 0;
        for (int i = 0; i < 16; i++) msg_blk[i] = '0;
        restart_message();
    end

    always @(posedge aclk) begin
        digest_word_t want;
        if (!aresetn) begin
            digest_q.delete();
            restart_message();
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $error("digest_word %h (word_index %0d) arrived with none expected",
                           m_tdata, m_tuser);
                    errs++;
                end else begin
                    want = digest_q.pop_front();
                    checked++;
                    if (m_tdata !== want.word) begin
                        $error("digest_word expected %h actual %h", want.word, m_tdata);
                        errs++;
                    end
                    if (m_tuser !== want.idx) begin
                        $error("word_index expected %0d actual %0d", want.idx, m_tuser);
                        errs++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_word expected %0b actual %0b", want.last, m_tlast);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                take_item(s_tdata, s_tuser, s_tlast);
            end
        end
        fail_count    <= errs;
        words_pending <= digest_q.size();
        words_checked <= checked;
    end

endmodule

// ----- test/sha256_byte_stream_hasher_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// sha256_byte_stream_hasher_tb
// Drives byte messages into the hasher and collects the digest words, with
// random idle cycles on both sides. A short directed part covers empty
// messages, single extreme bytes, bytes carrying the end flag and ignored
// transactions; random messages then hit the padding boundaries, including
// the extra length block. A separate checker predicts and compares.
// ============================================================================
module sha256_byte_stream_hasher_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int ITEM_TARGET    = 200;
    localparam int MESSAGE_TARGET = 12;
    localparam int EDGE_LENGTHS [6] = '{55, 56, 57, 63, 64, 65};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int   fail_count;
    int   words_pending;
    int   words_checked;
    int   idle_cycles    = 0;
    int   items_sent     = 0;
    int   messages_sent  = 0;
    int   bytes_sent     = 0;
    logic tx_steady      = 1'b0;
    logic rx_steady      = 1'b0;

    always #5 aclk = ~aclk;

    sha256_byte_stream_hasher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sha256_digest_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    task automatic send_item(input logic [7:0] d, input logic p, input logic e);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= p;
        s_tlast  <= e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (p || e) items_sent++;
        if (p) bytes_sent++;
        if (e) messages_sent++;
    endtask

    // stop sending and hold until every queued digest word has come out
    task automatic hold_for_digests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
    endtask

    task automatic send_message(input int len);
        logic fold_end;
        fold_end = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, fold_end && (i == len - 1));
        end
        if (!fold_end) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin : digest_sink
        int gap;
        @(posedge aclk);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int pick;
        int len;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        hold_for_digests();

        while (items_sent < ITEM_TARGET || messages_sent < MESSAGE_TARGET) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady <= ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 7);
            if (pick < 4) begin
                len = $urandom_range(0, 12);
            end else if (pick < 6) begin
                len = EDGE_LENGTHS[$urandom_range(0, 5)];
            end else begin
                len = $urandom_range(13, 70);
            end
            send_message(len);
        end
        hold_for_digests();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d messages, %0d bytes, %0d counted input transactions",
                 messages_sent, bytes_sent, items_sent);
        $display("compared %0d digest words, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0 && words_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sha_pkg.sv
rtl/sha_msg_buf.sv
rtl/sha_round_core.sv
rtl/sha256_byte_stream_hasher.sv
test/sha256_digest_checker.sv
test/sha256_byte_stream_hasher_tb.sv
